// ===== src/error_diffusion_binarizer_top_assert.svh =====
// ----------------------------------------------------------------------------
// error_diffusion_binarizer_top_assert: assertion macros
// shared concurrent assertion forms for the binarizer checkers
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_BINARIZER_TOP_ASSERT_SVH
`define ERROR_DIFFUSION_BINARIZER_TOP_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define EDB_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("binarizer check failed");

// consequent must hold in the cycle after the antecedent
`define EDB_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("binarizer check failed");

`endif

// ===== src/edb_pkg.sv =====
// ----------------------------------------------------------------------------
// edb_pkg: binarizer shared definitions
// sizes, register indexes and the datapath interface types
// ----------------------------------------------------------------------------
package edb_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;

    // column and row counter widths
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // error rows are split into even and odd column banks
    localparam int BANK_DEPTH = (MAX_WIDTH + 1) / 2;
    localparam int BANK_AW    = COL_W - 1;

    localparam int PIX_W        = 8;
    localparam int THR_W        = 8;
    localparam int ERR_W        = 11;
    localparam int WIDTH_REG_W  = 11;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD,
        REG_WIDTH,
        REG_HEIGHT
    } cfg_reg_t;

    typedef logic signed [ERR_W-1:0] err_t;

    typedef struct packed {
        logic last_col;
        logic last_row;
    } diff_ctrl_t;

    typedef struct packed {
        logic white;
        err_t carry_next;
        err_t next_x;
        err_t next_xm1;
        err_t next_xp1;
    } diff_out_t;

endpackage

// ===== src/error_diffusion_binarizer_top.sv =====
// ----------------------------------------------------------------------------
// error_diffusion_binarizer_top: floyd-steinberg grayscale to one-bit binarizer
// path: an input beat passes the input reg, then the result reg
// throughput: 1 pixel per cycle while out_stall is low; the right-carry error loop is carry_reg
// reset: counters, carry and window clear at once; error rows read as zero
// through a fill count, so there is no clearing pass and no wait after reset
// ----------------------------------------------------------------------------
module error_diffusion_binarizer_top
    import edb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration writes
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // pixel input channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PIX_W-1:0]      pixel_in,
    // result channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic                  pixel_white,
    output logic                  row_end,
    output logic                  frame_end
);

    localparam logic [THR_W-1:0]        THRESHOLD_RESET = 8'd128;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET     = 11'd640;
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET    = 13'd480;
    localparam logic [WIDTH_REG_W-1:0]  WIDTH_LIMIT     = WIDTH_REG_W'(MAX_WIDTH);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_LIMIT    = HEIGHT_REG_W'(MAX_HEIGHT);
    localparam err_t ERR_ZERO = '0;

    // configuration registers
    logic [THR_W-1:0]        threshold_reg;
    logic [THR_W-1:0]        threshold_next;
    logic [WIDTH_REG_W-1:0]  width_reg;
    logic [WIDTH_REG_W-1:0]  width_next;
    logic [HEIGHT_REG_W-1:0] height_reg;
    logic [HEIGHT_REG_W-1:0] height_next;
    logic [WIDTH_REG_W-1:0]  cfg_width;
    logic [HEIGHT_REG_W-1:0] cfg_height;

    // handshake and pipeline
    logic             in_full_reg;
    logic             in_full_next;
    logic [PIX_W-1:0] pixel_reg;
    logic             in_accept;
    logic             proc_fire;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             pixel_white_reg;
    logic             row_end_reg;
    logic             frame_end_reg;

    // position and diffusion state
    logic [COL_W-1:0]       column_count_reg;
    logic [COL_W-1:0]       column_count_next;
    logic [ROW_W-1:0]       row_count_reg;
    logic [ROW_W-1:0]       row_count_next;
    err_t                   carry_reg;
    err_t                   carry_next;
    err_t                   win_cur_reg;
    err_t                   win_cur_next;
    err_t                   win_prev_reg;
    err_t                   win_prev_next;
    logic [WIDTH_REG_W-1:0] fill_reg;
    logic [WIDTH_REG_W-1:0] fill_next;

    logic [WIDTH_REG_W-1:0]  x_plus1;
    logic [HEIGHT_REG_W-1:0] y_plus1;
    logic                    last_col;
    logic                    last_row;
    logic [COL_W-1:0]        col_after;
    logic [ROW_W-1:0]        row_after;
    logic [COL_W-1:0]        x_minus1;
    logic [COL_W-1:0]        rd_col;

    // error row banks
    logic [BANK_AW-1:0] bank_raddr;
    logic               ev_we;
    logic [BANK_AW-1:0] ev_waddr;
    err_t               ev_wdata;
    err_t               ev_rdata;
    logic               od_we;
    logic [BANK_AW-1:0] od_waddr;
    err_t               od_wdata;
    err_t               od_rdata;
    logic               ev_hit_reg;
    logic               ev_hit_next;
    err_t               ev_byp_reg;
    logic               od_hit_reg;
    logic               od_hit_next;
    err_t               od_byp_reg;
    err_t               bank_word;
    err_t               above_err;
    logic               wr_xm1;
    logic               wr_x;

    diff_ctrl_t diff_ctrl;
    diff_out_t  diff_res;

    // ------------------------------------------------------------------------
    // configuration: widths and heights are clamped to 1..max on write
    // ------------------------------------------------------------------------
    always_comb
    begin
        cfg_width = cfg_data[WIDTH_REG_W-1:0];
        if (cfg_width == '0)
        begin
            cfg_width = WIDTH_REG_W'(1);
        end
        else if (cfg_width > WIDTH_LIMIT)
        begin
            cfg_width = WIDTH_LIMIT;
        end

        cfg_height = cfg_data[HEIGHT_REG_W-1:0];
        if (cfg_height == '0)
        begin
            cfg_height = HEIGHT_REG_W'(1);
        end
        else if (cfg_height > HEIGHT_LIMIT)
        begin
            cfg_height = HEIGHT_LIMIT;
        end

        threshold_next = threshold_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_THRESHOLD: threshold_next = cfg_data[THR_W-1:0];
                REG_WIDTH:     width_next     = cfg_width;
                REG_HEIGHT:    height_next    = cfg_height;
                default:       ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // handshake: the input register fills while a result waits downstream;
    // the pixel in the input register is processed whenever the result
    // register is empty or being drained this cycle
    // ------------------------------------------------------------------------
    assign proc_fire = in_full_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_full_reg && !proc_fire;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_full_next = in_full_reg;
        if (in_accept)
        begin
            in_full_next = 1'b1;
        end
        else if (proc_fire)
        begin
            in_full_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (proc_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------------
    // position: geometry registers are read live, so a mid-frame change acts
    // at once and a count at or past the new end counts as the last one
    // ------------------------------------------------------------------------
    assign x_plus1   = WIDTH_REG_W'(column_count_reg) + WIDTH_REG_W'(1);
    assign y_plus1   = HEIGHT_REG_W'(row_count_reg) + HEIGHT_REG_W'(1);
    assign last_col  = x_plus1 >= width_reg;
    assign last_row  = y_plus1 >= height_reg;
    assign col_after = last_col ? '0 : x_plus1[COL_W-1:0];
    assign row_after = last_row ? '0 : y_plus1[ROW_W-1:0];
    assign x_minus1  = column_count_reg - COL_W'(1);

    // ------------------------------------------------------------------------
    // error row storage: one row in place, split by column parity so that
    // the two entries finished on the last pixel of a row go out together.
    // entry x is read ahead (address of the next pixel); entry x-1 of the
    // row below is written as pixel x finishes, and entry x too at row end.
    // entries at or above the fill count were not written by the last row
    // and read as zero
    // ------------------------------------------------------------------------
    assign rd_col     = proc_fire ? col_after : column_count_reg;
    assign bank_raddr = rd_col[COL_W-1:1];
    assign wr_xm1     = proc_fire && (column_count_reg != '0);
    assign wr_x       = proc_fire && last_col;

    always_comb
    begin
        if (!column_count_reg[0])
        begin
            ev_we    = wr_x;
            ev_waddr = column_count_reg[COL_W-1:1];
            ev_wdata = diff_res.next_x;
            od_we    = wr_xm1;
            od_waddr = x_minus1[COL_W-1:1];
            od_wdata = diff_res.next_xm1;
        end
        else
        begin
            ev_we    = wr_xm1;
            ev_waddr = x_minus1[COL_W-1:1];
            ev_wdata = diff_res.next_xm1;
            od_we    = wr_x;
            od_waddr = column_count_reg[COL_W-1:1];
            od_wdata = diff_res.next_x;
        end
    end

    // a read that meets a write to the same entry takes the written word
    assign ev_hit_next = ev_we && (ev_waddr == bank_raddr);
    assign od_hit_next = od_we && (od_waddr == bank_raddr);

    always_comb
    begin
        if (column_count_reg[0])
        begin
            bank_word = od_hit_reg ? od_byp_reg : od_rdata;
        end
        else
        begin
            bank_word = ev_hit_reg ? ev_byp_reg : ev_rdata;
        end
        above_err = (WIDTH_REG_W'(column_count_reg) < fill_reg) ? bank_word : ERR_ZERO;
    end

    edb_ram #(
        .DATA_W (ERR_W),
        .DEPTH  (BANK_DEPTH)
    ) u_even_bank (
        .clk     (clk),
        .we      (ev_we),
        .wr_addr (ev_waddr),
        .wr_data (ev_wdata),
        .rd_addr (bank_raddr),
        .rd_data (ev_rdata)
    );

    edb_ram #(
        .DATA_W (ERR_W),
        .DEPTH  (BANK_DEPTH)
    ) u_odd_bank (
        .clk     (clk),
        .we      (od_we),
        .wr_addr (od_waddr),
        .wr_data (od_wdata),
        .rd_addr (bank_raddr),
        .rd_data (od_rdata)
    );

    // ------------------------------------------------------------------------
    // diffusion datapath between the input register and the result register
    // ------------------------------------------------------------------------
    assign diff_ctrl.last_col = last_col;
    assign diff_ctrl.last_row = last_row;

    edb_diffuse u_diffuse (
        .pixel     (pixel_reg),
        .threshold (threshold_reg),
        .above_err (above_err),
        .carry_err (carry_reg),
        .win_cur   (win_cur_reg),
        .win_prev  (win_prev_reg),
        .ctrl      (diff_ctrl),
        .result    (diff_res)
    );

    // window: win_cur holds the row-below entry at x, win_prev the one at x-1
    always_comb
    begin
        column_count_next = column_count_reg;
        row_count_next    = row_count_reg;
        carry_next        = carry_reg;
        win_cur_next      = win_cur_reg;
        win_prev_next     = win_prev_reg;
        fill_next         = fill_reg;
        if (proc_fire)
        begin
            column_count_next = col_after;
            carry_next        = diff_res.carry_next;
            win_cur_next      = diff_res.next_xp1;
            win_prev_next     = diff_res.next_x;
            if (last_col)
            begin
                row_count_next = row_after;
                // frame end drops every stored error, row end keeps this row
                fill_next = last_row ? '0 : x_plus1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg    <= THRESHOLD_RESET;
            width_reg        <= WIDTH_RESET;
            height_reg       <= HEIGHT_RESET;
            in_full_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            column_count_reg <= '0;
            row_count_reg    <= '0;
            carry_reg        <= ERR_ZERO;
            win_cur_reg      <= ERR_ZERO;
            win_prev_reg     <= ERR_ZERO;
            fill_reg         <= '0;
            ev_hit_reg       <= 1'b0;
            od_hit_reg       <= 1'b0;
        end
        else
        begin
            threshold_reg    <= threshold_next;
            width_reg        <= width_next;
            height_reg       <= height_next;
            in_full_reg      <= in_full_next;
            out_valid_reg    <= out_valid_next;
            column_count_reg <= column_count_next;
            row_count_reg    <= row_count_next;
            carry_reg        <= carry_next;
            win_cur_reg      <= win_cur_next;
            win_prev_reg     <= win_prev_next;
            fill_reg         <= fill_next;
            ev_hit_reg       <= ev_hit_next;
            od_hit_reg       <= od_hit_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pixel_reg <= pixel_in;
        end
        if (proc_fire)
        begin
            pixel_white_reg <= diff_res.white;
            row_end_reg     <= last_col;
            frame_end_reg   <= last_col && last_row;
        end
        ev_byp_reg <= ev_wdata;
        od_byp_reg <= od_wdata;
    end

    assign out_valid   = out_valid_reg;
    assign pixel_white = pixel_white_reg;
    assign row_end     = row_end_reg;
    assign frame_end   = frame_end_reg;

endmodule

// ===== src/edb_ram.sv =====
// ----------------------------------------------------------------------------
// edb_ram: generic simple dual-port ram
// one write port and one read port, read data registered
// ----------------------------------------------------------------------------
module edb_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/edb_diffuse.sv =====
// ----------------------------------------------------------------------------
// edb_diffuse: per-pixel error diffusion datapath
// threshold decision, residual split into 7/3/5/1 sixteenths, window update
// ----------------------------------------------------------------------------
module edb_diffuse
    import edb_pkg::*;
(
    input  logic [PIX_W-1:0] pixel,
    input  logic [THR_W-1:0] threshold,
    input  err_t             above_err,
    input  err_t             carry_err,
    input  err_t             win_cur,
    input  err_t             win_prev,
    input  diff_ctrl_t       ctrl,
    output diff_out_t        result
);

    localparam int SUM_W  = ERR_W + 1;
    localparam int PROD_W = SUM_W + 4;
    localparam int FRAC_SHIFT = 4;

    localparam logic signed [SUM_W-1:0]  WHITE_LEVEL = SUM_W'(255);
    localparam logic signed [PROD_W-1:0] ROUND_BIAS  = PROD_W'((1 << FRAC_SHIFT) - 1);
    localparam err_t ERR_MAX = {1'b0, {(ERR_W-1){1'b1}}};
    localparam err_t ERR_MIN = {1'b1, {(ERR_W-1){1'b0}}};
    localparam err_t ERR_ZERO = '0;

    // clip a one-bit-wider sum back to the error range
    function automatic err_t sat_err(input logic signed [SUM_W-1:0] v);
        err_t r;
        if (v[SUM_W-1] == v[SUM_W-2])
        begin
            r = v[ERR_W-1:0];
        end
        else
        begin
            r = v[SUM_W-1] ? ERR_MIN : ERR_MAX;
        end
        return r;
    endfunction

    // e * k / 16 with truncation toward zero
    function automatic err_t share16(input logic signed [SUM_W-1:0] e,
                                     input logic signed [3:0] k);
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] biased;
        logic signed [PROD_W-1:0] quo;
        prod   = e * k;
        biased = prod + (prod[PROD_W-1] ? ROUND_BIAS : '0);
        quo    = biased >>> FRAC_SHIFT;
        return quo[ERR_W-1:0];
    endfunction

    logic signed [SUM_W-1:0] err_sum;
    err_t                    err;
    logic signed [SUM_W-1:0] pix_sum;
    logic                    white;
    logic signed [SUM_W-1:0] resid;
    err_t                    s7;
    err_t                    s5;
    err_t                    s3;
    err_t                    s1;
    logic signed [SUM_W-1:0] acc_x;
    logic signed [SUM_W-1:0] acc_xm1;

    assign err_sum = $signed({above_err[ERR_W-1], above_err})
                   + $signed({carry_err[ERR_W-1], carry_err});
    assign err     = sat_err(err_sum);
    assign pix_sum = $signed({{(SUM_W-PIX_W){1'b0}}, pixel}) + $signed({err[ERR_W-1], err});
    assign white   = pix_sum >= $signed({{(SUM_W-THR_W){1'b0}}, threshold});
    assign resid   = white ? (pix_sum - WHITE_LEVEL) : pix_sum;

    assign s7 = share16(resid, 4'sd7);
    assign s5 = share16(resid, 4'sd5);
    assign s3 = share16(resid, 4'sd3);
    assign s1 = share16(resid, 4'sd1);

    assign acc_x   = $signed({win_cur[ERR_W-1], win_cur}) + $signed({s5[ERR_W-1], s5});
    assign acc_xm1 = $signed({win_prev[ERR_W-1], win_prev}) + $signed({s3[ERR_W-1], s3});

    always_comb
    begin
        result.white      = white;
        result.carry_next = ctrl.last_col ? ERR_ZERO : s7;
        result.next_x     = ctrl.last_row ? win_cur : sat_err(acc_x);
        result.next_xm1   = ctrl.last_row ? win_prev : sat_err(acc_xm1);
        result.next_xp1   = (ctrl.last_row || ctrl.last_col) ? ERR_ZERO : s1;
    end

endmodule

// ===== src/edb_checker.sv =====
// ----------------------------------------------------------------------------
// edb_checker: port-level checks for the binarizer
// watches the result channel and the input stall, bound to the top level
// ----------------------------------------------------------------------------
`include "error_diffusion_binarizer_top_assert.svh"

module edb_checker (
    input logic clk,
    input logic rst_n,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic pixel_white,
    input logic row_end,
    input logic frame_end
);

    // result payload as one word
    logic [2:0] out_bits;

    assign out_bits = {pixel_white, row_end, frame_end};

    // a held result beat stays up and unchanged
    `EDB_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `EDB_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_bits))

    // the last pixel of a frame is always the last pixel of a row
    `EDB_ASSERT_SAME(a_frame_row, clk, rst_n, out_valid && frame_end, row_end)

    // input only backs up when a result is waiting and stalled
    `EDB_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)

endmodule

bind error_diffusion_binarizer_top edb_checker u_edb_checker (.*);
